// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Types, register map constants and helper functions that the six-channel
// compare timer and its checker share.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int NUM_CHANNELS = 6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  address;
        logic [15:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [5:0]  a_match_flags;
        logic [5:0]  b_match_flags;
    } out_item_t;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [15:0] CTL_KEEP_MASK = 16'h017d;
    localparam logic [15:0] CLKCTL_MASK   = 16'h000f;
    localparam logic [15:0] PAUSE_MASK    = 16'h003f;

    localparam logic [6:0] ADDR_DA0     = 7'h50;
    localparam logic [6:0] ADDR_DA2     = 7'h54;
    localparam logic [6:0] ADDR_PAUSE   = 7'h5c;
    localparam logic [6:0] ADDR_ADV     = 7'h5e;
    localparam logic [6:0] ADDR_CLK0    = 7'h60;
    localparam logic [6:0] ADDR_CLK5    = 7'h6a;
    localparam logic [6:0] ADDR_CH_END  = 7'd48;

    localparam logic [5:0] IDX_PAUSE = 6'd46;
    localparam logic [5:0] IDX_ADV   = 6'd47;
    localparam logic [5:0] IDX_CLK0  = 6'd48;

    localparam int B_RUN    = 0;
    localparam int B_PRESET = 1;
    localparam int B_OUTEN  = 2;
    localparam int B_EXTCLK = 3;
    localparam int B_OUTINV = 4;
    localparam int B_SELBUF = 5;
    localparam int B_INITOL = 8;
    localparam int B_PSON   = 3;

    // Channels whose compare A the three DA16 registers load.
    localparam logic [2:0] DA_FIRST  [3] = '{3'd1, 3'd3, 3'd5};
    localparam logic [2:0] DA_SECOND [3] = '{3'd2, 3'd4, 3'd0};

    typedef struct packed {
        logic [15:0] cnt;
        logic [15:0] a;
        logic [15:0] b;
        logic        am;
        logic        bm;
    } step_t;

    function automatic logic [12:0] div_of(input logic [2:0] sel);
        logic [12:0] d;
        unique case (sel)
            3'd0: d = 13'd1;
            3'd1: d = 13'd2;
            3'd2: d = 13'd4;
            3'd3: d = 13'd16;
            3'd4: d = 13'd64;
            3'd5: d = 13'd256;
            3'd6: d = 13'd1024;
            default: d = 13'd4096;
        endcase
        return d;
    endfunction

    // One counter clock of a channel.
    function automatic step_t clock_step(input logic [15:0] cnt, input logic [15:0] a,
                                         input logic [15:0] b, input logic [15:0] ba,
                                         input logic [15:0] bb, input logic selbuf);
        step_t r;
        r.cnt = cnt;
        r.a   = a;
        r.b   = b;
        r.am  = 1'b0;
        r.bm  = 1'b0;
        if (b != cnt) begin
            r.cnt = cnt + 16'd1;
            r.am  = (a == cnt + 16'd1);
        end else begin
            r.cnt = 16'd0;
            if (selbuf) begin
                r.a = ba;
                r.b = bb;
            end
            r.am = (r.a == 16'd0);
            r.bm = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sct_ram.sv =====
// ----------------------------------------------------------------------------
// sct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/six_channel_compare_timer.sv =====
// An accepted item is held in the stage register and then registered into m_item once the output is free.
// Throughput: one item per cycle while the output is not stalled; all six channels are updated in parallel on a tick.
// The plain register storage sits in a RAM read at acceptance, with a bypass for a
// write by the item ahead.
// Reset (aresetn low, synchronous) clears all timer registers to zero, the clock enable mask
// to all ones, and marks every RAM entry as reading zero.
// ----------------------------------------------------------------------------
// six_channel_compare_timer
// Six 16-bit compare-match channels with prescalers, bus reads and writes.
// ----------------------------------------------------------------------------
module six_channel_compare_timer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sct_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output sct_pkg::out_item_t m_item,
    input  logic              cfg_wr_en,
    input  logic [5:0]        cfg_wr_data
);

    localparam int NCH = sct_pkg::NUM_CHANNELS;

    logic               stage_valid_reg;
    sct_pkg::in_item_t  stage_item_reg;
    logic               m_valid_reg;
    sct_pkg::out_item_t m_item_reg;
    logic [5:0]         cen_mask_reg;

    logic [15:0] ctl_reg [NCH];
    logic [15:0] ctl_next [NCH];
    logic [15:0] clk_reg [NCH];
    logic [15:0] clk_next [NCH];
    logic [15:0] pause_reg, pause_next;
    logic [15:0] adv_reg, adv_next;
    logic [15:0] cnt_reg [NCH];
    logic [15:0] cnt_next [NCH];
    logic [11:0] psc_reg [NCH];
    logic [11:0] psc_next [NCH];
    logic [15:0] act_reg [2*NCH];
    logic [15:0] act_next [2*NCH];
    logic [15:0] buf_reg [2*NCH];
    logic [15:0] buf_next [2*NCH];

    logic [63:0] ram_vld_reg;
    logic        vld_cap_reg;
    logic        byp_hit_reg;
    logic [15:0] byp_data_reg;
    logic [15:0] ram_rd;
    logic [15:0] ram_q;
    logic        ram_we;
    logic [15:0] ram_wdata;

    logic               accept, advance;
    sct_pkg::out_item_t result;

    assign advance = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    sct_ram #(.WIDTH(16), .DEPTH(64)) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we && advance),
        .wr_addr (stage_item_reg.address[6:1]),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (s_item.address[6:1]),
        .rd_data (ram_rd)
    );

    assign ram_q = byp_hit_reg ? byp_data_reg : (vld_cap_reg ? ram_rd : 16'd0);

    always_comb begin
        logic [6:0]  addr;
        logic [5:0]  idx;
        logic [15:0] val;
        logic        adv;
        logic [2:0]  ch;
        logic [1:0]  sub;
        logic [15:0] raw;
        logic [15:0] st;
        logic [12:0] div;
        logic        pulse;
        logic        ch0_am, ch0_bm;
        sct_pkg::step_t r;

        addr   = stage_item_reg.address;
        idx    = addr[6:1];
        val    = stage_item_reg.write_data;
        adv    = adv_reg[0];
        ch     = addr[5:3];
        sub    = addr[2:1];
        ch0_am = 1'b0;
        ch0_bm = 1'b0;
        st     = 16'd0;
        div    = 13'd1;
        pulse  = 1'b0;
        r      = '0;

        ctl_next   = ctl_reg;
        clk_next   = clk_reg;
        pause_next = pause_reg;
        adv_next   = adv_reg;
        cnt_next   = cnt_reg;
        psc_next   = psc_reg;
        act_next   = act_reg;
        buf_next   = buf_reg;
        ram_we     = 1'b0;
        ram_wdata  = val;
        result     = '0;

        // Raw store entry: special registers live in flops, the rest in the RAM.
        raw = ram_q;
        for (int i = 0; i < NCH; i++) begin
            if (idx == 6'(4*i + 3)) raw = ctl_reg[i];
            if (idx == sct_pkg::IDX_CLK0 + 6'(i)) raw = clk_reg[i];
        end
        if (idx == sct_pkg::IDX_PAUSE) raw = pause_reg;
        if (idx == sct_pkg::IDX_ADV) raw = adv_reg;

        unique case (stage_item_reg.mode)
            sct_pkg::MODE_TICK: begin
                for (int i = 0; i < NCH; i++) begin
                    if (ctl_reg[i][sct_pkg::B_RUN] && !ctl_reg[i][sct_pkg::B_EXTCLK] &&
                        clk_reg[i][sct_pkg::B_PSON] && cen_mask_reg[i] &&
                        !(adv && pause_reg[i])) begin
                        div = sct_pkg::div_of(clk_reg[i][2:0]);
                        if ({1'b0, psc_reg[i]} + 13'd1 < div) begin
                            psc_next[i] = psc_reg[i] + 12'd1;
                        end else begin
                            psc_next[i] = 12'd0;
                            r = sct_pkg::clock_step(cnt_reg[i], act_reg[2*i], act_reg[2*i+1],
                                                    buf_reg[2*i], buf_reg[2*i+1],
                                                    ctl_reg[i][sct_pkg::B_SELBUF]);
                            cnt_next[i]     = r.cnt;
                            act_next[2*i]   = r.a;
                            act_next[2*i+1] = r.b;
                            result.a_match_flags[i] = r.am;
                            result.b_match_flags[i] = r.bm;
                            if (i == 0) begin
                                ch0_am = r.am;
                                ch0_bm = r.bm;
                            end
                        end
                    end
                end
                // Channel 5 on its external input counts output edges of channel 0.
                pulse = ctl_reg[0][sct_pkg::B_OUTINV] ? ch0_bm : ch0_am;
                if (ctl_reg[0][sct_pkg::B_OUTEN] && ctl_reg[5][sct_pkg::B_RUN] &&
                    ctl_reg[5][sct_pkg::B_EXTCLK] && cen_mask_reg[5] &&
                    !(adv && pause_reg[5]) && pulse) begin
                    r = sct_pkg::clock_step(cnt_reg[5], act_reg[10], act_reg[11],
                                            buf_reg[10], buf_reg[11],
                                            ctl_reg[5][sct_pkg::B_SELBUF]);
                    cnt_next[5] = r.cnt;
                    act_next[10] = r.a;
                    act_next[11] = r.b;
                    result.a_match_flags[5] = r.am;
                    result.b_match_flags[5] = r.bm;
                end
            end
            sct_pkg::MODE_READ: begin
                result.read_data = raw;
                if (addr == sct_pkg::ADDR_PAUSE) begin
                    result.read_data = pause_reg & sct_pkg::PAUSE_MASK;
                end else if (addr == sct_pkg::ADDR_ADV) begin
                    result.read_data = adv_reg & 16'd1;
                end else if (addr < sct_pkg::ADDR_CH_END && !addr[0]) begin
                    for (int i = 0; i < NCH; i++) begin
                        if (ch == 3'(i)) begin
                            unique case (sub)
                                2'd0, 2'd1: result.read_data = ctl_reg[i][sct_pkg::B_SELBUF] ?
                                    buf_reg[2*i + int'(sub[0])] : act_reg[2*i + int'(sub[0])];
                                2'd2: result.read_data = cnt_reg[i];
                                default: result.read_data = ctl_reg[i] & sct_pkg::CTL_KEEP_MASK;
                            endcase
                        end
                    end
                end else if (addr >= sct_pkg::ADDR_CLK0 && addr <= sct_pkg::ADDR_CLK5 &&
                             !addr[0]) begin
                    result.read_data = raw & sct_pkg::CLKCTL_MASK;
                end
            end
            sct_pkg::MODE_WRITE: begin
                if (addr == sct_pkg::ADDR_PAUSE) begin
                    if (adv) pause_next = val & sct_pkg::PAUSE_MASK;
                end else if (addr == sct_pkg::ADDR_ADV) begin
                    adv_next = val & 16'd1;
                end else if (addr >= sct_pkg::ADDR_DA0 && addr <= sct_pkg::ADDR_DA2 &&
                             !addr[0]) begin
                    if (adv) begin
                        ram_we = 1'b1;
                        for (int p = 0; p < 3; p++) begin
                            if (addr[2:1] == 2'(p)) begin
                                for (int i = 0; i < NCH; i++) begin
                                    if (sct_pkg::DA_FIRST[p] == 3'(i)) begin
                                        if (ctl_reg[i][sct_pkg::B_SELBUF])
                                            buf_next[2*i] = {6'd0, val[15:6]};
                                        else
                                            act_next[2*i] = {6'd0, val[15:6]};
                                    end
                                    if (sct_pkg::DA_SECOND[p] == 3'(i)) begin
                                        if (ctl_reg[i][sct_pkg::B_SELBUF])
                                            buf_next[2*i] = {10'd0, val[5:0]};
                                        else
                                            act_next[2*i] = {10'd0, val[5:0]};
                                    end
                                end
                            end
                        end
                    end
                end else if (addr < sct_pkg::ADDR_CH_END && !addr[0]) begin
                    for (int i = 0; i < NCH; i++) begin
                        if (ch == 3'(i)) begin
                            unique case (sub)
                                2'd0, 2'd1: begin
                                    if (ctl_reg[i][sct_pkg::B_SELBUF])
                                        buf_next[2*i + int'(sub[0])] = val;
                                    else
                                        act_next[2*i + int'(sub[0])] = val;
                                end
                                2'd2: begin
                                    if (adv) cnt_next[i] = val;
                                end
                                default: begin
                                    st = val & sct_pkg::CTL_KEEP_MASK;
                                    if (!adv) st[sct_pkg::B_INITOL] = ctl_reg[i][sct_pkg::B_INITOL];
                                    ctl_next[i] = st;
                                    if (val[sct_pkg::B_PRESET]) begin
                                        cnt_next[i] = 16'd0;
                                        psc_next[i] = 12'd0;
                                        // The preset loads through the new SELCRB setting.
                                        if (st[sct_pkg::B_SELBUF]) begin
                                            act_next[2*i]   = buf_reg[2*i];
                                            act_next[2*i+1] = buf_reg[2*i+1];
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end else if (addr >= sct_pkg::ADDR_CLK0 && addr <= sct_pkg::ADDR_CLK5 &&
                             !addr[0]) begin
                    for (int i = 0; i < NCH; i++) begin
                        if (idx == sct_pkg::IDX_CLK0 + 6'(i)) begin
                            clk_next[i] = val & sct_pkg::CLKCTL_MASK;
                            psc_next[i] = 12'd0;
                        end
                    end
                end else begin
                    ram_we = 1'b1;
                    for (int i = 0; i < NCH; i++) begin
                        if (idx == 6'(4*i + 3)) begin
                            ctl_next[i] = val;
                            ram_we = 1'b0;
                        end
                        if (idx == sct_pkg::IDX_CLK0 + 6'(i)) begin
                            clk_next[i] = val;
                            ram_we = 1'b0;
                        end
                    end
                    if (idx == sct_pkg::IDX_PAUSE) begin
                        pause_next = val;
                        ram_we = 1'b0;
                    end
                    if (idx == sct_pkg::IDX_ADV) begin
                        adv_next = val;
                        ram_we = 1'b0;
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            cen_mask_reg    <= 6'h3f;
            pause_reg       <= '0;
            adv_reg         <= '0;
            ram_vld_reg     <= '0;
            vld_cap_reg     <= 1'b0;
            byp_hit_reg     <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                ctl_reg[i] <= '0;
                clk_reg[i] <= '0;
                cnt_reg[i] <= '0;
                psc_reg[i] <= '0;
            end
            for (int i = 0; i < 2*NCH; i++) begin
                act_reg[i] <= '0;
                buf_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                cen_mask_reg <= cfg_wr_data;
            end
            if (accept) begin
                stage_valid_reg <= 1'b1;
                stage_item_reg  <= s_item;
                vld_cap_reg     <= ram_vld_reg[s_item.address[6:1]];
                // The item ahead writes the entry this item reads in the same cycle.
                byp_hit_reg     <= advance && ram_we &&
                                   (stage_item_reg.address[6:1] == s_item.address[6:1]);
                byp_data_reg    <= ram_wdata;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= result;
                ctl_reg     <= ctl_next;
                clk_reg     <= clk_next;
                pause_reg   <= pause_next;
                adv_reg     <= adv_next;
                cnt_reg     <= cnt_next;
                psc_reg     <= psc_next;
                act_reg     <= act_next;
                buf_reg     <= buf_next;
                if (ram_we) begin
                    ram_vld_reg[stage_item_reg.address[6:1]] <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/sct_checker.sv =====
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the six-channel compare timer, bound to the top level.
// ----------------------------------------------------------------------------
module sct_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input sct_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input sct_pkg::out_item_t m_item
);

    // A read gives no match flags and a tick reads as zero.
    a_read_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.read_data != 16'd0 |->
            m_item.a_match_flags == 6'd0 && m_item.b_match_flags == 6'd0)
        else $error("match flags set on a read item");

    // The input side only stalls when the output holds an item nobody takes.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output was free");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output item changed before it was taken");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind six_channel_compare_timer sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bus reads, writes and prescaler ticks into the six-channel compare
// timer, predicts every result item, and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    sct_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    sct_pkg::out_item_t m_item;
    logic               cfg_wr_en = 1'b0;
    logic [5:0]         cfg_wr_data = '0;

    six_channel_compare_timer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Timer model state.
    logic [15:0] regs [64];
    logic [15:0] counter [6];
    logic [15:0] cmp_act [12];
    logic [15:0] cmp_buf [12];
    logic [11:0] psc [6];
    logic [5:0]  clk_en;

    sct_pkg::in_item_t  pending_items [$];
    sct_pkg::out_item_t expected_results [$];
    int        mismatch_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        hold_off_cycles = 0;
    int        quiet_cycles = 0;
    logic      in_taken = 1'b0;

    function automatic logic ctl_bit(int ch, int b);
        return regs[ch * 4 + 3][b];
    endfunction

    function automatic logic adv();
        return regs[sct_pkg::IDX_ADV][0];
    endfunction

    function automatic int slot(int ch, int which);
        return ch * 2 + which;
    endfunction

    function automatic logic [15:0] cmp_get(int ch, int which);
        return ctl_bit(ch, sct_pkg::B_SELBUF) ? cmp_buf[slot(ch, which)]
                                              : cmp_act[slot(ch, which)];
    endfunction

    function automatic void cmp_set(int ch, int which, logic [15:0] v);
        if (ctl_bit(ch, sct_pkg::B_SELBUF)) cmp_buf[slot(ch, which)] = v;
        else cmp_act[slot(ch, which)] = v;
    endfunction

    function automatic void load_buf(int ch);
        if (ctl_bit(ch, sct_pkg::B_SELBUF)) begin
            cmp_act[2 * ch] = cmp_buf[2 * ch];
            cmp_act[2 * ch + 1] = cmp_buf[2 * ch + 1];
        end
    endfunction

    function automatic logic not_held(int ch);
        return clk_en[ch] && !(adv() && regs[sct_pkg::IDX_PAUSE][ch]);
    endfunction

    // Returns {B match, A match} for one counter clock.
    function automatic logic [1:0] count_once(int ch);
        logic [15:0] cnt;
        logic [16:0] to_a, to_b;
        logic [1:0]  res;
        cnt = counter[ch];
        to_b = {1'b0, 16'(cmp_act[2 * ch + 1] - cnt)} + 17'd1;
        to_a = {1'b0, 16'(cmp_act[2 * ch] - cnt)};
        res = 2'b00;
        if (to_a == 0) to_a = 17'h10000;
        if (to_a < to_b && to_a <= 1) res[0] = 1'b1;
        if (to_b > 1) begin
            counter[ch] = cnt + 16'd1;
            return res;
        end
        counter[ch] = '0;
        load_buf(ch);
        if (cmp_act[2 * ch] == 0) res[0] = 1'b1;
        res[1] = 1'b1;
        return res;
    endfunction

    function automatic void reset_timer();
        for (int i = 0; i < 64; i++) regs[i] = '0;
        for (int i = 0; i < 12; i++) begin
            cmp_act[i] = '0;
            cmp_buf[i] = '0;
        end
        for (int i = 0; i < 6; i++) begin
            counter[i] = '0;
            psc[i] = '0;
        end
        clk_en = 6'h3f;
    endfunction

    function automatic void bus_write(logic [6:0] addr, logic [15:0] val);
        int idx, ch, sub, pair;
        logic [15:0] st;
        idx = addr >> 1;
        if (addr == sct_pkg::ADDR_PAUSE) begin
            if (adv()) regs[idx] = val & sct_pkg::PAUSE_MASK;
        end else if (addr == sct_pkg::ADDR_ADV) begin
            regs[idx] = val & 16'h1;
        end else if (addr >= sct_pkg::ADDR_DA0 && addr <= sct_pkg::ADDR_DA2 && !addr[0]) begin
            if (adv()) begin
                pair = (addr - sct_pkg::ADDR_DA0) >> 1;
                regs[idx] = val;
                cmp_set(sct_pkg::DA_FIRST[pair], 0, val >> 6);
                cmp_set(sct_pkg::DA_SECOND[pair], 0, val & 16'h3f);
            end
        end else if (addr < sct_pkg::ADDR_CH_END && !addr[0]) begin
            ch = addr >> 3;
            sub = addr[2:1];
            if (sub < 2) begin
                cmp_set(ch, sub, val);
            end else if (sub == 2) begin
                if (adv()) counter[ch] = val;
            end else begin
                st = val & sct_pkg::CTL_KEEP_MASK;
                if (!adv()) st[sct_pkg::B_INITOL] = regs[idx][sct_pkg::B_INITOL];
                regs[idx] = st;
                if (val[sct_pkg::B_PRESET]) begin
                    counter[ch] = '0;
                    psc[ch] = '0;
                    load_buf(ch);
                end
            end
        end else if (addr >= sct_pkg::ADDR_CLK0 && addr <= sct_pkg::ADDR_CLK5 && !addr[0]) begin
            regs[idx] = val & sct_pkg::CLKCTL_MASK;
            psc[(addr - sct_pkg::ADDR_CLK0) >> 1] = '0;
        end else begin
            regs[idx] = val;
        end
    endfunction

    function automatic logic [15:0] bus_read(logic [6:0] addr);
        int idx, ch, sub;
        idx = addr >> 1;
        if (addr == sct_pkg::ADDR_PAUSE) return regs[idx] & sct_pkg::PAUSE_MASK;
        if (addr == sct_pkg::ADDR_ADV) return regs[idx] & 16'h1;
        if (addr < sct_pkg::ADDR_CH_END && !addr[0]) begin
            ch = addr >> 3;
            sub = addr[2:1];
            if (sub < 2) return cmp_get(ch, sub);
            if (sub == 2) return counter[ch];
            return regs[idx] & sct_pkg::CTL_KEEP_MASK;
        end
        if (addr >= sct_pkg::ADDR_CLK0 && addr <= sct_pkg::ADDR_CLK5 && !addr[0])
            return regs[idx] & sct_pkg::CLKCTL_MASK;
        return regs[idx];
    endfunction

    function automatic sct_pkg::out_item_t timer_response(sct_pkg::in_item_t it);
        sct_pkg::out_item_t r;
        logic [1:0] m, ch0;
        logic [15:0] cc;
        int div;
        r = '0;
        ch0 = 2'b00;
        if (it.mode == sct_pkg::MODE_TICK) begin
            for (int ch = 0; ch < sct_pkg::NUM_CHANNELS; ch++) begin
                cc = regs[sct_pkg::IDX_CLK0 + ch];
                if (!(ctl_bit(ch, sct_pkg::B_RUN) && !ctl_bit(ch, sct_pkg::B_EXTCLK) &&
                      cc[sct_pkg::B_PSON] && not_held(ch)))
                    continue;
                div = sct_pkg::div_of(cc[2:0]);
                if (int'(psc[ch]) + 1 < div) begin
                    psc[ch] = psc[ch] + 12'd1;
                    continue;
                end
                psc[ch] = '0;
                m = count_once(ch);
                r.a_match_flags[ch] = m[0];
                r.b_match_flags[ch] = m[1];
                if (ch == 0) ch0 = m;
            end
            if (ctl_bit(0, sct_pkg::B_OUTEN) && ctl_bit(5, sct_pkg::B_RUN) &&
                ctl_bit(5, sct_pkg::B_EXTCLK) && not_held(5)) begin
                if (ctl_bit(0, sct_pkg::B_OUTINV) ? ch0[1] : ch0[0]) begin
                    m = count_once(5);
                    if (m[0]) r.a_match_flags[5] = 1'b1;
                    if (m[1]) r.b_match_flags[5] = 1'b1;
                end
            end
        end else if (it.mode == sct_pkg::MODE_READ) begin
            r.read_data = bus_read(it.address);
        end else if (it.mode == sct_pkg::MODE_WRITE) begin
            bus_write(it.address, it.write_data);
        end
        return r;
    endfunction

    // Sender: offers queued items, changes at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_taken) begin
                // hold the item until it is taken
            end else if (pending_items.size() > 0 &&
                         $urandom_range(99, 0) >= sender_idle_pct) begin
                s_item <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge aclk) begin
        sct_pkg::out_item_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) expected_results.push_back(timer_response(s_item));
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) $display("unexpected item %h", m_item);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.read_data !== want.read_data ||
                        m_item.a_match_flags !== want.a_match_flags ||
                        m_item.b_match_flags !== want.b_match_flags) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("item mismatch: expected rd %h a %b b %b, got rd %h a %b b %b",
                                     want.read_data, want.a_match_flags, want.b_match_flags,
                                     m_item.read_data, m_item.a_match_flags,
                                     m_item.b_match_flags);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("six_channel_compare_timer: mismatch");
            $finish;
        end
    end

    function automatic sct_pkg::in_item_t make_item(logic [1:0] mode, logic [6:0] addr,
                                                    logic [15:0] d);
        sct_pkg::in_item_t it;
        it.mode = mode;
        it.address = addr;
        it.write_data = d;
        return it;
    endfunction

    function automatic void queue_write(logic [6:0] addr, logic [15:0] d);
        pending_items.push_back(make_item(sct_pkg::MODE_WRITE, addr, d));
    endfunction

    function automatic void queue_read(logic [6:0] addr);
        pending_items.push_back(make_item(sct_pkg::MODE_READ, addr, 16'($urandom)));
    endfunction

    function automatic void queue_ticks(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(make_item(sct_pkg::MODE_TICK, 7'($urandom), 16'($urandom)));
    endfunction

    // Random channel setup with small compares so matches happen often.
    function automatic void queue_setup();
        for (int ch = 0; ch < sct_pkg::NUM_CHANNELS; ch++) begin
            logic [15:0] c;
            c = 16'($urandom_range(0, 3)) << sct_pkg::B_SELBUF |
                16'($urandom) & 16'h011c | 16'h0001;
            if ($urandom_range(3, 0) == 0) c[sct_pkg::B_RUN] = 1'b0;
            if (ch != 5 && $urandom_range(3, 0) != 0) c[sct_pkg::B_EXTCLK] = 1'b0;
            queue_write(7'(ch * 8 + 6), c);
            queue_write(7'(ch * 8), 16'($urandom_range(12, 0)));
            queue_write(7'(ch * 8 + 2), 16'($urandom_range(14, 0)));
            queue_write(7'(sct_pkg::ADDR_CLK0 + 2 * ch),
                        16'($urandom_range(7, 0) < 6 ? $urandom_range(2, 0) : $urandom_range(7, 0))
                        | ($urandom_range(7, 0) != 0 ? 16'h8 : 16'h0) | 16'($urandom) & 16'hfff0);
        end
    endfunction

    function automatic void queue_random(int n);
        int k;
        logic [6:0] a;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99, 0);
            a = ($urandom_range(3, 0) == 0) ? 7'($urandom) : 7'($urandom_range('h6b, 0));
            if (k < 55) queue_ticks(1);
            else if (k < 78) queue_read(a);
            else if (k < 97) queue_write(a, $urandom_range(1, 0) ? 16'($urandom)
                                            : 16'($urandom_range(20, 0)));
            else pending_items.push_back(make_item(2'd3, a, 16'($urandom)));
        end
    endfunction

    task automatic drain_and_config(logic [5:0] mask);
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mask;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        clk_en = mask;
    endtask

    initial begin
        reset_timer();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, counter wrap, modes, advanced-mode writes, chaining.
        queue_read(7'h00);
        queue_write(7'h7f, 16'hffff);
        queue_read(7'h7f);
        queue_write(7'h04, 16'h1234);
        queue_write(sct_pkg::ADDR_PAUSE, 16'hffff);
        queue_write(sct_pkg::ADDR_ADV, 16'hffff);
        queue_write(7'h04, 16'hfffe);
        queue_write(7'h02, 16'h0001);
        queue_write(7'h00, 16'h0000);
        queue_write(sct_pkg::ADDR_CLK0, 16'hfff8);
        queue_write(7'h06, 16'hffff);
        queue_write(7'h06, 16'h0115);
        queue_write(7'h2e, 16'h0029);
        queue_write(sct_pkg::ADDR_DA0, 16'hffff);
        queue_write(sct_pkg::ADDR_DA2, 16'h0041);
        queue_ticks(6);
        pending_items.push_back(make_item(2'd3, 7'h7f, 16'hffff));
        queue_write(sct_pkg::ADDR_PAUSE, 16'h0001);
        queue_ticks(2);
        queue_read(sct_pkg::ADDR_PAUSE);
        queue_read(7'h04);
        queue_write(sct_pkg::ADDR_ADV, 16'h0000);

        // Phases: no idling, sender idle, receiver stall, both, with a long hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            queue_setup();
            queue_write(sct_pkg::ADDR_ADV, 16'($urandom_range(1, 0)));
            queue_write(sct_pkg::ADDR_PAUSE, 16'($urandom) & 16'h0003);
            queue_random(210);
            if (ph == 4) hold_off_cycles = 300;
            drain_and_config(ph == 7 ? 6'h3f : (ph == 2 ? 6'h00 : 6'($urandom)));
        end
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("six_channel_compare_timer: match");
        end else begin
            $display("six_channel_compare_timer: mismatch");
        end
        $finish;
    end
endmodule
